FILE: sv/ffsn_pkg.sv
// ---------------------------------------------------------------------------
// ffsn_pkg
// Shared constants, codes, types and direction tables for the flow-field
// steepest-neighbour block.
// ---------------------------------------------------------------------------
package ffsn_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int DIST_BITS_DEF   = 32;
   localparam int MAX_HEIGHT      = 4096;
   localparam int WIDTH_RESET     = 64;
   localparam int HEIGHT_RESET    = 64;
   localparam int QUEUE_DEPTH     = 4;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int IN_DIST_BITS    = 32;
   localparam int FLOW_BITS       = 16;
   localparam int DIR_BITS        = 4;

   // rows run up to height+1 while the tail drains
   localparam int ROW_BITS        = 13;

   localparam logic signed [FLOW_BITS-1:0] UNIT_Q14 = 16'sd16384;
   localparam logic signed [FLOW_BITS-1:0] DIAG_Q14 = 16'sd11585;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_WIDTH  = 4'd0,
      CSR_GRID_HEIGHT = 4'd1
   } ffsn_csr_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_NONE = 4'd0,
      DIR_N    = 4'd1,
      DIR_NE   = 4'd2,
      DIR_E    = 4'd3,
      DIR_SE   = 4'd4,
      DIR_S    = 4'd5,
      DIR_SW   = 4'd6,
      DIR_W    = 4'd7,
      DIR_NW   = 4'd8
   } ffsn_dir_type;

   // per-item control from front to back; edge flags mask out-of-grid neighbours
   typedef struct packed {
      logic has_res;
      logic last;
      logic up;
      logic down;
      logic left;
      logic right;
   } ffsn_tag_type;

   function automatic logic signed [FLOW_BITS-1:0] flow_x(input ffsn_dir_type d);
      logic signed [FLOW_BITS-1:0] v;
      case (d)
         DIR_NE, DIR_SE: v = DIAG_Q14;
         DIR_E:          v = UNIT_Q14;
         DIR_SW, DIR_NW: v = -DIAG_Q14;
         DIR_W:          v = -UNIT_Q14;
         default:        v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [FLOW_BITS-1:0] flow_y(input ffsn_dir_type d);
      logic signed [FLOW_BITS-1:0] v;
      case (d)
         DIR_SE, DIR_SW: v = DIAG_Q14;
         DIR_S:          v = UNIT_Q14;
         DIR_NE, DIR_NW: v = -DIAG_Q14;
         DIR_N:          v = -UNIT_Q14;
         default:        v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/flow_field_steepest_neighbour.sv
// ---------------------------------------------------------------------------
// flow_field_steepest_neighbour
// Steepest-descent 8-neighbour flow vector for a raster-ordered distance map.
// ---------------------------------------------------------------------------
//  port group | dir | handshake             | carries
//  req_*      | in  | req_valid/req_ready   | cell_distance, flush
//  rsp_*      | out | rsp_valid/rsp_ready   | flow_x, flow_y, direction, last
//  csr_*      | in  | csr_write_en (no wait)| 0 grid_width, 1 grid_height
//
//  One transaction per clock in and out while neither side stalls; rsp_valid
//  rises once the transaction completing a window has passed the queue, line
//  store read, compare-input register, three tree stages and result register.
//  Results lag the cell by one row + 1.
//  The line store is one RAM port pair (read column, write back as s1 advances).
//  Synchronous reset, no clearing pass; line store is left as is.
//  A stalled rsp side freezes the back half; req stalls once the 4-entry
//  queue fills.
// ---------------------------------------------------------------------------
module flow_field_steepest_neighbour #(
   parameter int  MAX_WIDTH = ffsn_pkg::MAX_WIDTH_DEF,
   parameter int  DIST_BITS = ffsn_pkg::DIST_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ffsn_pkg::IN_DIST_BITS-1:0]     req_cell_distance,
   input  logic                                  req_flush,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_x,
   output logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_y,
   output logic [ffsn_pkg::DIR_BITS-1:0]         rsp_direction,
   output logic                                  rsp_last,
   input  logic                                  csr_write_en,
   input  logic [ffsn_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ffsn_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int TB = $bits(ffsn_pkg::ffsn_tag_type);
   localparam int QW = DIST_BITS + CB + TB;

   logic                   push;
   logic [DIST_BITS-1:0]   push_dist;
   logic [CB-1:0]          push_col;
   ffsn_pkg::ffsn_tag_type push_tag;
   logic                   cfg_restart;
   logic                   q_full;
   logic                   q_not_empty;
   logic                   pop;
   logic [QW-1:0]          q_head;

   ffsn_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .DIST_BITS (DIST_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_distance (req_cell_distance),
      .req_flush         (req_flush),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_full            (q_full),
      .push              (push),
      .push_dist         (push_dist),
      .push_col          (push_col),
      .push_tag          (push_tag),
      .cfg_restart       (cfg_restart)
   );

   ffsn_queue #(
      .WIDTH (QW),
      .DEPTH (ffsn_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_dist, push_col, push_tag}),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (q_head)
   );

   ffsn_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .DIST_BITS (DIST_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .restart       (cfg_restart),
      .head_valid    (q_not_empty),
      .head_dist     (q_head[QW-1 -: DIST_BITS]),
      .head_col      (q_head[TB +: CB]),
      .head_tag      (ffsn_pkg::ffsn_tag_type'(q_head[TB-1:0])),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_flow_x    (rsp_flow_x),
      .rsp_flow_y    (rsp_flow_y),
      .rsp_direction (rsp_direction),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: sv/ffsn_ram.sv
// ---------------------------------------------------------------------------
// ffsn_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffsn_ram #(
   parameter int  WIDTH = 64,
   parameter int  DEPTH = 1024,
   localparam int AB    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AB-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AB-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ffsn_queue.sv
// ---------------------------------------------------------------------------
// ffsn_queue
// Short FIFO between the front and back halves.
// ---------------------------------------------------------------------------
module ffsn_queue #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PB = $clog2(DEPTH);
   localparam int NB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == NB'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

endmodule

FILE: sv/ffsn_front.sv
// ---------------------------------------------------------------------------
// ffsn_front
// Input side: configuration, raster position counters and classification
// of each transaction (dropped flush, cell, drain step, result due).
// ---------------------------------------------------------------------------
module ffsn_front #(
   parameter int  MAX_WIDTH = ffsn_pkg::MAX_WIDTH_DEF,
   parameter int  DIST_BITS = ffsn_pkg::DIST_BITS_DEF,
   localparam int CB        = $clog2(MAX_WIDTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ffsn_pkg::IN_DIST_BITS-1:0]   req_cell_distance,
   input  logic                                req_flush,
   input  logic                                csr_write_en,
   input  logic [ffsn_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ffsn_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                q_full,
   output logic                                push,
   output logic [DIST_BITS-1:0]                push_dist,
   output logic [CB-1:0]                       push_col,
   output ffsn_pkg::ffsn_tag_type              push_tag,
   output logic                                cfg_restart
);

   localparam int WB = CB + 1;
   localparam int RB = ffsn_pkg::ROW_BITS;
   localparam int WIDTH_RESET_EFF =
      (ffsn_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ffsn_pkg::WIDTH_RESET;

   logic [WB-1:0] width_ff, width_in;
   logic [RB-1:0] height_ff, height_in;
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;

   logic [31:0]   wclamp;
   logic [31:0]   hclamp;
   logic          accept;
   logic          in_frame;
   logic          is_end;
   logic          is_mid;
   logic [RB:0]   height_p1;
   logic          row_is_hp1;
   logic [WB-1:0] col_next;
   ffsn_pkg::ffsn_tag_type tag;

   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;
   assign cfg_restart = csr_write_en &&
                        (csr_index == ffsn_pkg::CSR_GRID_WIDTH ||
                         csr_index == ffsn_pkg::CSR_GRID_HEIGHT);

   // configuration, clamped to the supported range on write
   always_comb begin
      wclamp    = 32'(csr_wdata[ffsn_pkg::CFG_WIDTH_BITS-1:0]);
      hclamp    = 32'(csr_wdata[ffsn_pkg::CFG_HEIGHT_BITS-1:0]);
      width_in  = width_ff;
      height_in = height_ff;
      if (wclamp == 32'd0) begin
         wclamp = 32'd1;
      end else if (wclamp > 32'(MAX_WIDTH)) begin
         wclamp = 32'(MAX_WIDTH);
      end
      if (hclamp == 32'd0) begin
         hclamp = 32'd1;
      end else if (hclamp > 32'(ffsn_pkg::MAX_HEIGHT)) begin
         hclamp = 32'(ffsn_pkg::MAX_HEIGHT);
      end
      if (csr_write_en && csr_index == ffsn_pkg::CSR_GRID_WIDTH) begin
         width_in = wclamp[WB-1:0];
      end
      if (csr_write_en && csr_index == ffsn_pkg::CSR_GRID_HEIGHT) begin
         height_in = hclamp[RB-1:0];
      end
   end

   // classification; a result at column 0 belongs to the row-end cell two rows up
   always_comb begin
      in_frame   = row_ff < height_ff;
      is_end     = (col_ff == '0) && (row_ff >= RB'(2));
      is_mid     = (col_ff != '0) && (row_ff != '0);
      height_p1  = {1'b0, height_ff} + (RB + 1)'(1);
      row_is_hp1 = ({1'b0, row_ff} == height_p1);

      tag.has_res = is_end || is_mid;
      tag.last    = is_end && row_is_hp1;
      tag.up      = is_end ? (row_ff == RB'(2)) : (row_ff == RB'(1));
      tag.down    = is_end ? row_is_hp1 : (row_ff == height_ff);
      tag.left    = is_end ? (width_ff == WB'(1)) : (col_ff == CB'(1));
      tag.right   = is_end ? 1'b1 : ({1'b0, col_ff} == width_ff);

      push      = accept && !(in_frame && req_flush);
      push_dist = in_frame ? req_cell_distance[DIST_BITS-1:0] : '1;
      push_col  = col_ff;
      push_tag  = tag;

      col_next = {1'b0, col_ff} + WB'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (push) begin
         if (tag.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next == width_ff) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
         end else begin
            col_in = col_next[CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(WIDTH_RESET_EFF);
         height_ff <= RB'(ffsn_pkg::HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

FILE: sv/ffsn_back.sv
// ---------------------------------------------------------------------------
// ffsn_back
// Execution side: line store update, 3x3 window, registered compare tree
// and the result register.
// ---------------------------------------------------------------------------
module ffsn_back #(
   parameter int  MAX_WIDTH = ffsn_pkg::MAX_WIDTH_DEF,
   parameter int  DIST_BITS = ffsn_pkg::DIST_BITS_DEF,
   localparam int CB        = $clog2(MAX_WIDTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  logic                                  head_valid,
   input  logic [DIST_BITS-1:0]                  head_dist,
   input  logic [CB-1:0]                         head_col,
   input  ffsn_pkg::ffsn_tag_type                head_tag,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_x,
   output logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_y,
   output logic [ffsn_pkg::DIR_BITS-1:0]         rsp_direction,
   output logic                                  rsp_last
);

   localparam int DB = DIST_BITS;
   localparam int LW = 2 * DB;                   // {older, previous}
   localparam int EW = DB + ffsn_pkg::DIR_BITS;  // {distance, direction}
   localparam logic [DB-1:0] UNREACH = '1;

   typedef struct packed {
      logic unreach;
      logic last;
   } flags_type;

   // first minimum wins: later entry only if strictly smaller
   function automatic logic [EW-1:0] pick(input logic [EW-1:0] a, input logic [EW-1:0] b);
      return (b[EW-1:ffsn_pkg::DIR_BITS] < a[EW-1:ffsn_pkg::DIR_BITS]) ? b : a;
   endfunction

   function automatic logic [DB-1:0] mask(input logic off, input logic [DB-1:0] v);
      return off ? UNREACH : v;
   endfunction

   logic                   adv;
   logic                   s1_valid_ff;
   logic [DB-1:0]          s1_dist_ff;
   logic [CB-1:0]          s1_col_ff;
   ffsn_pkg::ffsn_tag_type s1_tag_ff;

   logic                   ram_we;
   logic [LW-1:0]          ram_wdata;
   logic [LW-1:0]          ram_rdata;
   logic                   fwd_sel_ff;
   logic [LW-1:0]          fwd_data_ff;
   logic [LW-1:0]          line;

   logic [DB-1:0]          win_ff [3][3];
   logic [DB-1:0]          nw     [3][3];
   logic [EW-1:0]          c9_in  [9];

   logic                   v2_ff, v3_ff, v4_ff, v5_ff;
   flags_type              fl2_ff, fl3_ff, fl4_ff, fl5_ff;
   logic [EW-1:0]          c9_ff  [9];
   logic [EW-1:0]          c5_ff  [5];
   logic [EW-1:0]          c3_ff  [3];
   logic [EW-1:0]          c2_ff  [2];
   logic [EW-1:0]          c1;
   ffsn_pkg::ffsn_dir_type dir;

   logic                   rsp_valid_ff;
   logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_x_ff;
   logic signed [ffsn_pkg::FLOW_BITS-1:0] rsp_flow_y_ff;
   ffsn_pkg::ffsn_dir_type rsp_dir_ff;
   logic                   rsp_last_ff;

   assign adv    = !rsp_valid_ff || rsp_ready;
   assign pop    = adv && head_valid;
   assign ram_we = adv && s1_valid_ff;
   assign line   = fwd_sel_ff ? fwd_data_ff : ram_rdata;
   assign ram_wdata = {line[DB-1:0], s1_dist_ff};

   ffsn_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wdata),
      .rd_en   (pop),
      .rd_addr (head_col),
      .rd_data (ram_rdata)
   );

   // window after the shift; masked entries read as unreachable
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nw[k][0] = win_ff[k][1];
         nw[k][1] = win_ff[k][2];
      end
      nw[0][2] = line[LW-1:DB];
      nw[1][2] = line[DB-1:0];
      nw[2][2] = s1_dist_ff;

      c9_in[0] = {nw[1][1], ffsn_pkg::DIR_NONE};
      c9_in[1] = {mask(s1_tag_ff.up, nw[0][1]), ffsn_pkg::DIR_N};
      c9_in[2] = {mask(s1_tag_ff.up || s1_tag_ff.right, nw[0][2]), ffsn_pkg::DIR_NE};
      c9_in[3] = {mask(s1_tag_ff.right, nw[1][2]), ffsn_pkg::DIR_E};
      c9_in[4] = {mask(s1_tag_ff.down || s1_tag_ff.right, nw[2][2]), ffsn_pkg::DIR_SE};
      c9_in[5] = {mask(s1_tag_ff.down, nw[2][1]), ffsn_pkg::DIR_S};
      c9_in[6] = {mask(s1_tag_ff.down || s1_tag_ff.left, nw[2][0]), ffsn_pkg::DIR_SW};
      c9_in[7] = {mask(s1_tag_ff.left, nw[1][0]), ffsn_pkg::DIR_W};
      c9_in[8] = {mask(s1_tag_ff.up || s1_tag_ff.left, nw[0][0]), ffsn_pkg::DIR_NW};

      c1  = pick(c2_ff[0], c2_ff[1]);
      dir = fl5_ff.unreach ? ffsn_pkg::DIR_NONE :
            ffsn_pkg::ffsn_dir_type'(c1[ffsn_pkg::DIR_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_sel_ff   <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= head_valid;
         v2_ff        <= s1_valid_ff && s1_tag_ff.has_res;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
         if (pop) begin
            // back-to-back access to one column: the read misses the write in flight
            fwd_sel_ff <= ram_we && (s1_col_ff == head_col);
         end
      end

      if (reset || restart) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= UNREACH;
            end
         end
      end else if (adv && s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= s1_tag_ff.last ? UNREACH : nw[k][j];
            end
         end
      end

      if (pop) begin
         s1_dist_ff  <= head_dist;
         s1_col_ff   <= head_col;
         s1_tag_ff   <= head_tag;
         fwd_data_ff <= ram_wdata;
      end

      if (adv) begin
         c9_ff          <= c9_in;
         fl2_ff.unreach <= (nw[1][1] == UNREACH);
         fl2_ff.last    <= s1_tag_ff.last;
         for (int i = 0; i < 4; i++) begin
            c5_ff[i] <= pick(c9_ff[2 * i], c9_ff[2 * i + 1]);
         end
         c5_ff[4] <= c9_ff[8];
         fl3_ff   <= fl2_ff;
         c3_ff[0] <= pick(c5_ff[0], c5_ff[1]);
         c3_ff[1] <= pick(c5_ff[2], c5_ff[3]);
         c3_ff[2] <= c5_ff[4];
         fl4_ff   <= fl3_ff;
         c2_ff[0] <= pick(c3_ff[0], c3_ff[1]);
         c2_ff[1] <= c3_ff[2];
         fl5_ff   <= fl4_ff;
         rsp_flow_x_ff <= ffsn_pkg::flow_x(dir);
         rsp_flow_y_ff <= ffsn_pkg::flow_y(dir);
         rsp_dir_ff    <= dir;
         rsp_last_ff   <= fl5_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_flow_x    = rsp_flow_x_ff;
   assign rsp_flow_y    = rsp_flow_y_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow-field steepest-neighbour block. Raster
// frames of distances go in over the req_ channel; an in-bench line-store and
// window model predicts each flow vector, which is checked field by field
// against the rsp_ channel in order. Covers directed patterns, register
// clamping and masking, unused register index, and random frames with
// random idles on both channels.
// ---------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FLOW_W           = ffsn_pkg::FLOW_BITS;
   localparam int          DIST_W           = ffsn_pkg::IN_DIST_BITS;
   localparam int          CFG_W_BITS       = ffsn_pkg::CFG_WIDTH_BITS;
   localparam int          CFG_H_BITS       = ffsn_pkg::CFG_HEIGHT_BITS;
   localparam int          CSR_IDX_W        = ffsn_pkg::CSR_INDEX_BITS;
   localparam int          CSR_DAT_W        = ffsn_pkg::CSR_DATA_BITS;
   localparam int          MAX_W            = ffsn_pkg::MAX_WIDTH_DEF;
   localparam int          RANDOM_ITEMS     = 900;
   localparam int          QUIET_CYCLES     = 24;
   localparam longint      CYCLE_LIMIT      = 4000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 4'hF;

   typedef struct {
      logic signed [FLOW_W-1:0] fx;
      logic signed [FLOW_W-1:0] fy;
      ffsn_pkg::ffsn_dir_type   dir;
      logic                     last;
   } flow_result_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [DIST_W-1:0]             req_cell_distance;
   logic                          req_flush;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [FLOW_W-1:0]      rsp_flow_x;
   logic signed [FLOW_W-1:0]      rsp_flow_y;
   logic [ffsn_pkg::DIR_BITS-1:0] rsp_direction;
   logic                          rsp_last;
   logic                          csr_write_en;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CSR_DAT_W-1:0]          csr_wdata;

   flow_field_steepest_neighbour dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_distance (req_cell_distance),
      .req_flush         (req_flush),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flow_x        (rsp_flow_x),
      .rsp_flow_y        (rsp_flow_y),
      .rsp_direction     (rsp_direction),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- flow predictor ----------------
   logic [CFG_W_BITS-1:0]  cfg_width;
   logic [CFG_H_BITS-1:0]  cfg_height;
   logic [DIST_W-1:0]      line_prev  [MAX_W];
   logic [DIST_W-1:0]      line_older [MAX_W];
   logic [DIST_W-1:0]      dist_window [3][3];
   int                     in_col;
   int                     in_row;
   flow_result_type        expected_flow_q [$];

   int     mismatch_count = 0;
   int     accepted_items = 0;
   longint cycle_count    = 0;
   bit     req_calm       = 1'b0;
   bit     rsp_calm       = 1'b0;
   int     rsp_stall      = 0;
   flow_result_type oldest;

   function automatic int active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > ffsn_pkg::MAX_HEIGHT) return ffsn_pkg::MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   function automatic void restart_frame_state();
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dist_window[i][j] = '1;
         end
      end
      in_col = 0;
      in_row = 0;
   endfunction

   function automatic void dir_offset(input ffsn_pkg::ffsn_dir_type d, output int dx,
                                      output int dy);
      case (d)
         ffsn_pkg::DIR_N:  begin dx =  0; dy = -1; end
         ffsn_pkg::DIR_NE: begin dx =  1; dy = -1; end
         ffsn_pkg::DIR_E:  begin dx =  1; dy =  0; end
         ffsn_pkg::DIR_SE: begin dx =  1; dy =  1; end
         ffsn_pkg::DIR_S:  begin dx =  0; dy =  1; end
         ffsn_pkg::DIR_SW: begin dx = -1; dy =  1; end
         ffsn_pkg::DIR_W:  begin dx = -1; dy =  0; end
         ffsn_pkg::DIR_NW: begin dx = -1; dy = -1; end
         default:          begin dx =  0; dy =  0; end
      endcase
   endfunction

   // steepest in-grid neighbour of the window column 'centre'; first in order wins ties
   function automatic void push_flow(input int centre, input int oy, input int ox,
                                     input int w, input int h);
      logic [DIST_W-1:0]      best;
      ffsn_pkg::ffsn_dir_type pick;
      int                     dx, dy, nx, ny, pos, mag;
      flow_result_type        res;
      best = dist_window[1][centre];
      pick = ffsn_pkg::DIR_NONE;
      if (best != '1) begin
         for (int d = int'(ffsn_pkg::DIR_N); d <= int'(ffsn_pkg::DIR_NW); d++) begin
            dir_offset(ffsn_pkg::ffsn_dir_type'(d), dx, dy);
            nx  = ox + dx;
            ny  = oy + dy;
            pos = centre + dx;
            if (nx < 0 || nx >= w || ny < 0 || ny >= h || pos < 0 || pos > 2) continue;
            if (dist_window[1 + dy][pos] < best) begin
               best = dist_window[1 + dy][pos];
               pick = ffsn_pkg::ffsn_dir_type'(d);
            end
         end
      end
      dir_offset(pick, dx, dy);
      mag = (dx != 0 && dy != 0) ? int'(ffsn_pkg::DIAG_Q14) : int'(ffsn_pkg::UNIT_Q14);
      res.fx   = FLOW_W'(dx * mag);
      res.fy   = FLOW_W'(dy * mag);
      res.dir  = pick;
      res.last = (oy == h - 1 && ox == w - 1);
      expected_flow_q.insert(expected_flow_q.size(), res);
   endfunction

   function automatic void predict_item(input logic [DIST_W-1:0] cell_dist,
                                        input logic flush);
      int                w, h, r, c;
      logic [DIST_W-1:0] d;
      bit                frame_done;
      w = active_width();
      h = active_height();
      r = in_row;
      c = in_col;
      d = cell_dist;
      frame_done = 1'b0;
      // flush while cells are still due: no effect at all
      if (r < h && flush) return;
      if (r >= h) d = '1;
      if (c >= w) c = 0;
      if (c == 0 && r >= 2) begin
         push_flow(2, r - 2, w - 1, w, h);
         frame_done = (r - 2 == h - 1);
      end
      for (int k = 0; k < 3; k++) begin
         dist_window[k][0] = dist_window[k][1];
         dist_window[k][1] = dist_window[k][2];
      end
      dist_window[0][2] = line_older[c];
      dist_window[1][2] = line_prev[c];
      dist_window[2][2] = d;
      line_older[c] = line_prev[c];
      line_prev[c]  = d;
      if (c >= 1 && r >= 1) push_flow(1, r - 1, c - 1, w, h);
      if (frame_done) begin
         restart_frame_state();
         return;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      in_col = c;
      in_row = r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DIST_W-1:0] random_distance();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 6);
         5:             return $urandom_range(0, 2);
         6:             return '1;
         7:             return $urandom();
         8:             return 32'hFFFF_FFFE;
         default:       return 32'h0;
      endcase
   endfunction

   task automatic send_item(input logic [DIST_W-1:0] cell_dist, input logic flush);
      int gap;
      req_valid         <= 1'b1;
      req_cell_distance <= cell_dist;
      req_flush         <= flush;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cell_dist, flush);
      gap = (req_calm || $urandom_range(0, 99) < 65) ? 0 : random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_flow_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      if (index == ffsn_pkg::CSR_GRID_WIDTH) begin
         cfg_width = value[CFG_W_BITS-1:0];
         restart_frame_state();
      end else if (index == ffsn_pkg::CSR_GRID_HEIGHT) begin
         cfg_height = value[CFG_H_BITS-1:0];
         restart_frame_state();
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // cells with the odd ignored flush mixed in
   task automatic send_cells(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(random_distance(), 1'b1);
         send_item(random_distance(), 1'b0);
         accepted_items++;
      end
   endtask

   task automatic send_drain();
      int w;
      w = active_width();
      for (int i = 0; i <= w; i++) begin
         send_item(random_distance(), $urandom_range(0, 3) != 0);
         accepted_items++;
      end
   endtask

   task automatic send_frame();
      send_cells(active_width() * active_height());
      send_drain();
   endtask

   // ---------------- tests ----------------
   task automatic test_directed_patterns();
      logic [DIST_W-1:0] grid [9];
      grid = '{32'hFFFF_FFFF, 32'h0, 32'h7,
               32'h3, 32'h5, 32'hFFFF_FFFE,
               32'h3, 32'h1, 32'h5};
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'd3);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++) begin
         send_item(grid[i], 1'b0);
         if (i == 3) send_item(32'h0, 1'b1);       // ignored mid-frame
         if (i == 4) wait_for_results();           // sender holds until all results are in
      end
      // drain items: out of frame the flush bit is ignored, high or low
      send_item(32'h0, 1'b0);
      send_item(32'h2, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h1, 1'b1);
      // flat map: every cell is a local minimum
      wait_for_results();
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'd2);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd2);
      repeat (4) send_item(32'h9, 1'b0);
      repeat (3) send_item(32'h9, 1'b1);
      wait_for_results();
   endtask

   task automatic test_register_limits();
      // zero sizes act as one
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'd0);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd0);
      send_frame();
      send_frame();
      wait_for_results();
      // write to an unused index mid-frame leaves the frame running
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'd5);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd4);
      send_cells(8);
      wait_for_results();
      write_reg(CSR_UNUSED_INDEX, 13'h1FFF);
      send_cells(12);
      send_drain();
      wait_for_results();
      // bits above the width field are dropped
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'h1802);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd3);
      send_frame();
      wait_for_results();
      // oversized width acts as the maximum; cut short by the next register write
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'h07FF);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'd2);
      send_cells(1030);
      wait_for_results();
      // oversized height, cut short
      write_reg(ffsn_pkg::CSR_GRID_WIDTH, 13'd1);
      write_reg(ffsn_pkg::CSR_GRID_HEIGHT, 13'h1FFF);
      send_cells(40);
      wait_for_results();
   endtask

   task automatic test_random_frames();
      int start_items, w, h, total, frames, split, roll;
      bit cut;
      start_items = accepted_items;
      while (accepted_items - start_items < RANDOM_ITEMS) begin
         wait_for_results();
         req_calm = ($urandom_range(0, 5) == 0);
         rsp_calm = ($urandom_range(0, 5) == 0);
         roll = $urandom_range(0, 19);
         if (roll < 13) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
         end else if (roll < 19) begin
            w = $urandom_range(7, 40);
            h = $urandom_range(1, 16);
         end else begin
            w = $urandom_range(41, 120);
            h = $urandom_range(1, 2);
         end
         write_reg(ffsn_pkg::CSR_GRID_WIDTH, CSR_DAT_W'(w));
         if ($urandom_range(0, 4) != 0 || active_height() > 16)
            write_reg(ffsn_pkg::CSR_GRID_HEIGHT, CSR_DAT_W'(h));
         total  = active_width() * active_height();
         frames = $urandom_range(1, 3);
         cut    = 1'b0;
         for (int f = 0; f < frames && !cut; f++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               send_cells($urandom_range(0, total - 1));
               cut = 1'b1;
            end else if (roll == 1) begin
               split = $urandom_range(0, total);
               send_cells(split);
               wait_for_results();
               send_cells(total - split);
               send_drain();
            end else begin
               send_frame();
            end
         end
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 9) == 0) rsp_stall = random_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_flow_q.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual dir %0d last %0d",
                     $time, rsp_direction, rsp_last);
            mismatch_count++;
         end else begin
            oldest = expected_flow_q.pop_front();
            if (rsp_flow_x !== oldest.fx) begin
               $display("%0t flow_x: expected %0d actual %0d", $time, oldest.fx, rsp_flow_x);
               mismatch_count++;
            end
            if (rsp_flow_y !== oldest.fy) begin
               $display("%0t flow_y: expected %0d actual %0d", $time, oldest.fy, rsp_flow_y);
               mismatch_count++;
            end
            if (rsp_direction !== oldest.dir) begin
               $display("%0t direction: expected %0d actual %0d", $time, oldest.dir,
                        rsp_direction);
               mismatch_count++;
            end
            if (rsp_last !== oldest.last) begin
               $display("%0t last: expected %0d actual %0d", $time, oldest.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_flow_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cell_distance = '0;
      req_flush         = 1'b0;
      rsp_ready         = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = ffsn_pkg::CSR_GRID_WIDTH;
      csr_wdata         = '0;
      cfg_width         = CFG_W_BITS'(ffsn_pkg::WIDTH_RESET);
      cfg_height        = CFG_H_BITS'(ffsn_pkg::HEIGHT_RESET);
      for (int i = 0; i < MAX_W; i++) begin
         line_prev[i]  = '0;
         line_older[i] = '0;
      end
      restart_frame_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_patterns();
      test_register_limits();
      test_random_frames();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/ffsn_pkg.sv
sv/ffsn_ram.sv
sv/ffsn_queue.sv
sv/ffsn_front.sv
sv/ffsn_back.sv
sv/flow_field_steepest_neighbour.sv
tb/tb_top.sv
